### design/rwz_pkg.sv
// ----------------------------------------------------------------------------
// rwz_pkg
// Shared types and constants for the rolling window z-score block.
// ----------------------------------------------------------------------------
`default_nettype none

package rwz_pkg;

  localparam int WINDOW_MAX  = 128;
  localparam int PTR_BITS    = $clog2(WINDOW_MAX);
  localparam int LEN_BITS    = PTR_BITS + 1;
  localparam int SAMPLE_BITS = 16;
  localparam int USER_IN_BITS  = 1;
  localparam int USER_OUT_BITS = 2;
  localparam int Z_BITS      = 16;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RECENT_WINDOW = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEASON_WINDOW = 8'd1;
  localparam logic [CFG_DATA_BITS-1:0]  RECENT_WINDOW_RST = 8'd5;
  localparam logic [CFG_DATA_BITS-1:0]  SEASON_WINDOW_RST = 8'd82;

  // datapath widths
  localparam int SUM_BITS   = 24;
  localparam int SQ_BITS    = 40;
  localparam int MUL_A_BITS = 16;
  localparam int MUL_B_BITS = 64;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
  localparam int DEN_BITS   = 46;
  localparam int NUM_BITS   = 32;
  localparam int AN_BITS    = 31;
  localparam int NR2_BITS   = 15;
  localparam int A_BITS     = 52;
  localparam int ASQ_BITS   = 61;
  localparam int C_BITS     = 66;
  localparam int QUO_BITS   = 31;
  localparam int ROOT_BITS  = 16;
  localparam int SREM_BITS  = 18;

  localparam logic [ROOT_BITS-1:0] Z_POS_LIMIT = 16'd32767;
  localparam logic [ROOT_BITS:0]   Z_NEG_LIMIT = 17'd32768;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] recent_window;
    logic [CFG_DATA_BITS-1:0] season_window;
  } rwz_cfg_t;

  typedef struct packed {
    logic [Z_BITS-1:0] zscore;
    logic              saturated;
    logic              degenerate;
  } rwz_result_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_P1,
    ST_SQ_LO,
    ST_SQ_HI,
    ST_NUM_R,
    ST_NUM_S,
    ST_NR2,
    ST_A,
    ST_AN_LO,
    ST_AN_HI,
    ST_C,
    ST_B,
    ST_DIV_LOAD,
    ST_DIV_CHK,
    ST_DIV,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_DONE
  } rwz_state_t;

endpackage

`default_nettype wire

### design/rolling_window_z_score.sv
// ----------------------------------------------------------------------------
// rolling_window_z_score
// Rolling z-score of a Q12.4 series: recent-window mean minus season-window
// mean over the season sample standard deviation, as saturating Q8.8.
//
// channel  dir  handshake               payload
// s_axis   in   s_axis_tvalid/tready    tdata: sample; tuser: new_series
// m_axis   out  m_axis_tvalid/tready    tdata: zscore; tuser: saturated,
//                                       degenerate
// cfg      in   cfg_valid/cfg_ready     cfg_index, cfg_data (8-bit window)
//
// A transaction runs from accept to result through a pass over max(nr, ns)
// history entries, nr and ns being the effective window lengths; a quotient
// overflow skips the divider, and degenerate cases skip the divider and the
// square root. The pass makes one read per cycle from the history memory;
// the divider takes 31 steps and the square root 16 steps.
// rst is synchronous; it clears the history count and restores the window
// registers. A result waits in the output register while the next sample is
// taken; the core holds its finished result until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_window_z_score (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rwz_pkg::SAMPLE_BITS-1:0]     s_axis_tdata,   // [15:0] sample
  input  logic [rwz_pkg::USER_IN_BITS-1:0]    s_axis_tuser,   // [0] new_series
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rwz_pkg::Z_BITS-1:0]          m_axis_tdata,   // [15:0] zscore
  output logic [rwz_pkg::USER_OUT_BITS-1:0]   m_axis_tuser,   // [0] saturated,
                                                              // [1] degenerate
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rwz_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rwz_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import rwz_pkg::*;

  rwz_cfg_t    cfg;
  rwz_result_t res;
  logic        res_valid;
  logic        res_ready;

  assign cfg_ready = 1'b1;
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.recent_window <= RECENT_WINDOW_RST;
      cfg.season_window <= SEASON_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RECENT_WINDOW: cfg.recent_window <= cfg_data;
        REG_SEASON_WINDOW: cfg.season_window <= cfg_data;
        default: ;
      endcase
    end
  end

  rwz_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_sample     (s_axis_tdata),
    .in_new_series (s_axis_tuser[0]),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= res.zscore;
      m_axis_tuser <= {res.degenerate, res.saturated};
    end
  end

endmodule

`default_nettype wire

### design/rwz_ring.sv
// ----------------------------------------------------------------------------
// rwz_ring
// Sample history memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rwz_ring (
  input  logic                             clk,
  input  logic                             we,
  input  logic [rwz_pkg::PTR_BITS-1:0]     waddr,
  input  logic [rwz_pkg::SAMPLE_BITS-1:0]  wdata,
  input  logic [rwz_pkg::PTR_BITS-1:0]     raddr,
  output logic [rwz_pkg::SAMPLE_BITS-1:0]  rdata
);
  import rwz_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/rwz_mul.sv
// ----------------------------------------------------------------------------
// rwz_mul
// Shared unsigned 16 x 64 multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module rwz_mul (
  input  logic                            clk,
  input  logic [rwz_pkg::MUL_A_BITS-1:0]  a,
  input  logic [rwz_pkg::MUL_B_BITS-1:0]  b,
  output logic [rwz_pkg::MUL_P_BITS-1:0]  prod
);
  import rwz_pkg::*;

  always_ff @(posedge clk) begin
    prod <= MUL_P_BITS'(a) * MUL_P_BITS'(b);
  end

endmodule

`default_nettype wire

### design/rwz_core.sv
// ----------------------------------------------------------------------------
// rwz_core
// Sequencer and datapath: history sweep, moment products, restoring divide
// and integer square root, all around one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rwz_core (
  input  logic                            clk,
  input  logic                            rst,
  input  rwz_pkg::rwz_cfg_t               cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rwz_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                            in_new_series,
  output logic                            res_valid,
  input  logic                            res_ready,
  output rwz_pkg::rwz_result_t            res
);
  import rwz_pkg::*;

  function automatic logic [LEN_BITS-1:0] eff_len(
    input logic [CFG_DATA_BITS-1:0] win,
    input logic [LEN_BITS-1:0]      held_cnt
  );
    logic [LEN_BITS-1:0] n;
    n = LEN_BITS'(win);
    if (win == '0) n = LEN_BITS'(1);
    if (win > CFG_DATA_BITS'(WINDOW_MAX)) n = LEN_BITS'(WINDOW_MAX);
    if (n > held_cnt) n = held_cnt;
    return n;
  endfunction

  rwz_state_t state, state_next;

  logic [PTR_BITS-1:0]  wp;
  logic [LEN_BITS-1:0]  held;
  logic [LEN_BITS-1:0]  nr, ns, nmax;
  logic [PTR_BITS-1:0]  cnt;
  logic                 rv, rv_r, rv_s, sqv;
  logic signed [SUM_BITS-1:0] sum_r, sum_s;
  logic [SQ_BITS-1:0]   sum_q;
  logic [DEN_BITS-1:0]  dd;
  logic signed [NUM_BITS-1:0] num;
  logic [AN_BITS-1:0]   an;
  logic [NR2_BITS-1:0]  nr2;
  logic [A_BITS-1:0]    aa;
  logic [ASQ_BITS-1:0]  bb;
  logic [C_BITS-1:0]    cc;
  logic [C_BITS-1:0]    rem;
  logic [QUO_BITS-1:0]  qb;
  logic [2*ROOT_BITS-1:0] sq_src;
  logic [SREM_BITS-1:0] srem;
  logic [ROOT_BITS-1:0] root;
  logic                 degen;

  logic                    start;
  logic [PTR_BITS-1:0]     wp_base;
  logic [LEN_BITS-1:0]     held_base, held_new, nr_new, ns_new;
  logic [PTR_BITS-1:0]     ring_raddr;
  logic [SAMPLE_BITS-1:0]  ring_rdata;
  logic signed [SAMPLE_BITS-1:0] v;
  logic [SAMPLE_BITS-1:0]  v_mag;
  logic [SUM_BITS-1:0]     sr_mag, ss_mag;
  logic [NUM_BITS-1:0]     num_mag;
  logic signed [NUM_BITS-1:0] prod_s;
  logic [MUL_A_BITS-1:0]   mul_a;
  logic [MUL_B_BITS-1:0]   mul_b;
  logic [MUL_P_BITS-1:0]   prod;
  logic [C_BITS:0]         div_r, div_diff;
  logic                    div_ge;
  logic [SREM_BITS+1:0]    sq_t, sq_trial, sq_diff;
  logic                    sq_ge;
  logic [ROOT_BITS:0]      neg_mag;
  logic [ROOT_BITS:0]      neg_z;

  assign start     = in_valid && in_ready;
  assign wp_base   = in_new_series ? '0 : wp;
  assign held_base = in_new_series ? '0 : held;
  assign held_new  = (held_base == LEN_BITS'(WINDOW_MAX)) ? held_base
                                                          : held_base + LEN_BITS'(1);
  assign nr_new    = eff_len(cfg.recent_window, held_new);
  assign ns_new    = eff_len(cfg.season_window, held_new);

  assign v       = ring_rdata;
  assign v_mag   = ring_rdata[SAMPLE_BITS-1] ? -ring_rdata : ring_rdata;
  assign sr_mag  = sum_r[SUM_BITS-1] ? SUM_BITS'(-sum_r) : SUM_BITS'(sum_r);
  assign ss_mag  = sum_s[SUM_BITS-1] ? SUM_BITS'(-sum_s) : SUM_BITS'(sum_s);
  assign num_mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
  assign prod_s  = prod[NUM_BITS-1:0];

  assign div_r    = {rem, qb[QUO_BITS-1]};
  assign div_ge   = div_r >= {1'b0, cc};
  assign div_diff = div_r - {1'b0, cc};

  assign sq_t     = {srem, sq_src[2*ROOT_BITS-1 -: 2]};
  assign sq_trial = (SREM_BITS+2)'({root, 2'b01});
  assign sq_ge    = sq_t >= sq_trial;
  assign sq_diff  = sq_t - sq_trial;

  rwz_ring u_ring (
    .clk   (clk),
    .we    (start),
    .waddr (wp_base),
    .wdata (in_sample),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  rwz_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    ring_raddr = wp - PTR_BITS'(1) - cnt;
    mul_a      = v_mag;
    mul_b      = MUL_B_BITS'(v_mag);
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if ({1'b0, cnt} == nmax - LEN_BITS'(1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rv) state_next = ST_P1;
      end
      ST_P1: begin
        mul_a      = MUL_A_BITS'(ns);
        mul_b      = MUL_B_BITS'(sum_q);
        state_next = ST_SQ_LO;
      end
      ST_SQ_LO: begin
        mul_a      = ss_mag[MUL_A_BITS-1:0];
        mul_b      = MUL_B_BITS'(ss_mag);
        state_next = ST_SQ_HI;
      end
      ST_SQ_HI: begin
        mul_a      = MUL_A_BITS'(ss_mag[SUM_BITS-1:MUL_A_BITS]);
        mul_b      = MUL_B_BITS'(ss_mag);
        state_next = ST_NUM_R;
      end
      ST_NUM_R: begin
        mul_a      = MUL_A_BITS'(ns);
        mul_b      = MUL_B_BITS'(sr_mag);
        state_next = ST_NUM_S;
      end
      ST_NUM_S: begin
        mul_a = MUL_A_BITS'(nr);
        mul_b = MUL_B_BITS'(ss_mag);
        if (ns < LEN_BITS'(2) || dd == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_NR2;
        end
      end
      ST_NR2: begin
        mul_a      = MUL_A_BITS'(nr);
        mul_b      = MUL_B_BITS'(nr);
        state_next = ST_A;
      end
      ST_A: begin
        mul_a      = MUL_A_BITS'(ns);
        mul_b      = MUL_B_BITS'(dd);
        state_next = ST_AN_LO;
      end
      ST_AN_LO: begin
        mul_a      = an[MUL_A_BITS-1:0];
        mul_b      = MUL_B_BITS'(an);
        state_next = ST_AN_HI;
      end
      ST_AN_HI: begin
        mul_a      = MUL_A_BITS'(an[AN_BITS-1:MUL_A_BITS]);
        mul_b      = MUL_B_BITS'(an);
        state_next = ST_C;
      end
      ST_C: begin
        mul_a      = MUL_A_BITS'(nr2);
        mul_b      = MUL_B_BITS'(aa);
        state_next = ST_B;
      end
      ST_B: begin
        mul_a      = MUL_A_BITS'(ns - LEN_BITS'(1));
        mul_b      = MUL_B_BITS'(bb);
        state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        state_next = ST_DIV_CHK;
      end
      ST_DIV_CHK: begin
        state_next = (rem >= cc) ? ST_SQRT_LOAD : ST_DIV;
      end
      ST_DIV: begin
        if (cnt == PTR_BITS'(QUO_BITS-1)) state_next = ST_SQRT_LOAD;
      end
      ST_SQRT_LOAD: begin
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt == PTR_BITS'(ROOT_BITS-1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      held <= '0;
      rv   <= 1'b0;
      sqv  <= 1'b0;
    end else begin
      rv  <= (state == ST_SWEEP);
      sqv <= rv && rv_s;
      if (start) begin
        wp   <= wp_base + PTR_BITS'(1);
        held <= held_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    rv_r <= ({1'b0, cnt} < nr);
    rv_s <= ({1'b0, cnt} < ns);

    if (start) begin
      sum_r <= '0;
      sum_s <= '0;
      sum_q <= '0;
    end else begin
      if (rv) begin
        if (rv_r) sum_r <= sum_r + SUM_BITS'(v);
        if (rv_s) sum_s <= sum_s + SUM_BITS'(v);
      end
      if (sqv) sum_q <= sum_q + SQ_BITS'(prod[2*SAMPLE_BITS-1:0]);
    end

    case (state)
      ST_IDLE: begin
        if (start) begin
          nr   <= nr_new;
          ns   <= ns_new;
          nmax <= (nr_new > ns_new) ? nr_new : ns_new;
          cnt  <= '0;
        end
      end
      ST_SWEEP:  cnt <= cnt + PTR_BITS'(1);
      ST_SQ_LO:  dd  <= prod[DEN_BITS-1:0];
      ST_SQ_HI:  dd  <= dd - prod[DEN_BITS-1:0];
      ST_NUM_R:  dd  <= dd - {prod[DEN_BITS-17:0], 16'd0};
      ST_NUM_S: begin
        num   <= sum_r[SUM_BITS-1] ? -prod_s : prod_s;
        degen <= (ns < LEN_BITS'(2)) || (dd == '0);
      end
      ST_NR2:    num <= sum_s[SUM_BITS-1] ? num + prod_s : num - prod_s;
      ST_A: begin
        nr2 <= prod[NR2_BITS-1:0];
        an  <= num_mag[AN_BITS-1:0];
      end
      ST_AN_LO:  aa <= prod[A_BITS-1:0];
      ST_AN_HI:  bb <= prod[ASQ_BITS-1:0];
      ST_C:      bb <= bb + {prod[ASQ_BITS-17:0], 16'd0};
      ST_B:      cc <= prod[C_BITS-1:0];
      ST_DIV_LOAD: begin
        // B = prod << 16; the divider starts on B >> QUO_BITS
        rem <= C_BITS'(prod[MUL_P_BITS-1:QUO_BITS-16]);
        qb  <= {prod[QUO_BITS-17:0], 16'd0};
        cnt <= '0;
      end
      ST_DIV_CHK: begin
        if (rem >= cc) qb <= '1;
      end
      ST_DIV: begin
        rem <= div_ge ? div_diff[C_BITS-1:0] : div_r[C_BITS-1:0];
        qb  <= {qb[QUO_BITS-2:0], div_ge};
        cnt <= cnt + PTR_BITS'(1);
      end
      ST_SQRT_LOAD: begin
        sq_src <= {1'b0, qb};
        srem   <= '0;
        root   <= '0;
        cnt    <= '0;
      end
      ST_SQRT: begin
        srem   <= sq_ge ? sq_diff[SREM_BITS-1:0] : sq_t[SREM_BITS-1:0];
        root   <= {root[ROOT_BITS-2:0], sq_ge};
        sq_src <= {sq_src[2*ROOT_BITS-3:0], 2'b00};
        cnt    <= cnt + PTR_BITS'(1);
      end
      default: ;
    endcase
  end

  assign neg_mag = ({1'b0, root} > Z_NEG_LIMIT) ? Z_NEG_LIMIT : {1'b0, root};
  assign neg_z   = -neg_mag;

  always_comb begin
    res.degenerate = degen;
    if (degen) begin
      res.zscore    = '0;
      res.saturated = 1'b0;
    end else if (num[NUM_BITS-1]) begin
      res.saturated = ({1'b0, root} > Z_NEG_LIMIT);
      res.zscore    = neg_z[Z_BITS-1:0];
    end else begin
      res.saturated = (root > Z_POS_LIMIT);
      res.zscore    = (root > Z_POS_LIMIT) ? Z_POS_LIMIT : root;
    end
  end

endmodule

`default_nettype wire
